FILE: rtl/ncl1_pkg.sv
// Shared types and constants for the nearest-codeword L1 search block.
// Used by ncl1_lane, ncl1_merge and nearest_codeword_l1_search; no dependencies.
`default_nettype none

package ncl1_pkg;

    localparam int ELEM_W      = 16;   // signed Q7.8 element
    localparam int ABS_W       = 16;   // |a - b| of two 16-bit signed values
    localparam int IDX_W       = 6;    // codeword_index / texton_index
    localparam int CHUNK_W     = 3;    // chunk_index
    localparam int DIST_W      = 22;   // L1 distance
    localparam int CFG_W       = 7;    // active_codewords
    localparam int NFIELDS     = 8;    // element fields carried per request
    localparam int IN_TDATA_W  = 144;  // 6 + 3 + 8*16 = 137, padded to bytes
    localparam int OUT_TDATA_W = 32;   // 6 + 22 = 28, padded to bytes

    localparam logic [CFG_W-1:0] ACTIVE_RESET = 7'd64;

    localparam logic CMD_LOAD = 1'b0;
    localparam logic CMD_DESC = 1'b1;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_SCAN,
        ST_DRAIN,
        ST_DONE
    } t_state;

    // Per-row tag travelling down the distance pipeline
    typedef struct packed {
        logic valid;
        logic first;   // first chunk of a codeword
        logic last;    // last chunk of a codeword
        logic final_cw; // last chunk of the last searched codeword
    } t_tag;

endpackage

`default_nettype wire

FILE: rtl/nearest_codeword_l1_search.sv
// Nearest-codeword search (L1), top level. Uses ncl1_pkg, ncl1_lane, ncl1_merge.
// Load and non-final descriptor requests are taken back to back, one per cycle.
// A final descriptor chunk scans n*NCHUNKS codebook rows, one per cycle (n = searched
// codewords, NCHUNKS = ceil(DIM/LANES)); each row then passes the read, lane, merge and
// accumulate registers. The result becomes valid as tready returns, later while an earlier result waits.
// Reset (i_rst_n low, sync) clears control, active_codewords = 64; memories unset until written.
`default_nettype none

module nearest_codeword_l1_search #(
    parameter int VOCAB = 64,
    parameter int DIM   = 40,
    parameter int LANES = 8
) (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_rst_n,
    // configuration: active_codewords
    input  wire logic                                 i_cfg_wen,
    input  wire logic [ncl1_pkg::CFG_W-1:0]           i_cfg_wdata,
    // request stream
    input  wire logic                                 s_axis_tvalid,
    output logic                                      s_axis_tready,
    // [5:0] codeword_index, [8:6] chunk_index, [24:9] elem_0 ... [136:121] elem_7,
    // [143:137] zero
    input  wire logic [ncl1_pkg::IN_TDATA_W-1:0]      s_axis_tdata,
    // [0] cmd
    input  wire logic                                 s_axis_tuser,
    // result stream
    output logic                                      m_axis_tvalid,
    input  wire logic                                 m_axis_tready,
    // [5:0] texton_index, [27:6] min_distance, [31:28] zero
    output logic [ncl1_pkg::OUT_TDATA_W-1:0]          m_axis_tdata
);

    localparam int NCHUNKS = (DIM + LANES - 1) / LANES;
    localparam int CH_W    = (NCHUNKS > 1) ? $clog2(NCHUNKS) : 1;
    localparam int CW_W    = $clog2(VOCAB);
    localparam int ROWS    = VOCAB * NCHUNKS;
    localparam int RA_W    = $clog2(ROWS);
    localparam int ROW_W   = LANES * ncl1_pkg::ELEM_W;
    localparam int EW      = ncl1_pkg::ELEM_W;
    localparam int FIELD0  = ncl1_pkg::IDX_W + ncl1_pkg::CHUNK_W; // first element bit

    // ---------------------------------------------------------------
    // Request decode
    // ---------------------------------------------------------------
    logic                          w_accept;
    logic                          w_cmd;
    logic [ncl1_pkg::IDX_W-1:0]    w_in_cw;
    logic [ncl1_pkg::CHUNK_W-1:0]  w_in_ch;
    logic                          w_ch_ok;
    logic                          w_cb_we;
    logic                          w_ds_we;
    logic                          w_start;
    logic [RA_W-1:0]               w_cb_waddr;
    logic [ROW_W-1:0]              w_row;

    assign w_accept = s_axis_tvalid && s_axis_tready;
    assign w_cmd    = s_axis_tuser;
    assign w_in_cw  = s_axis_tdata[ncl1_pkg::IDX_W-1:0];
    assign w_in_ch  = s_axis_tdata[FIELD0-1:ncl1_pkg::IDX_W];
    assign w_ch_ok  = 32'(w_in_ch) < 32'(NCHUNKS);

    assign w_cb_we  = w_accept && (w_cmd == ncl1_pkg::CMD_LOAD) && w_ch_ok
                      && (32'(w_in_cw) < 32'(VOCAB));
    assign w_ds_we  = w_accept && (w_cmd == ncl1_pkg::CMD_DESC) && w_ch_ok;
    // last descriptor chunk kicks off the search
    assign w_start  = w_accept && (w_cmd == ncl1_pkg::CMD_DESC)
                      && (32'(w_in_ch) == 32'(NCHUNKS - 1));

    assign w_cb_waddr = RA_W'(32'(w_in_cw) * 32'(NCHUNKS) + 32'(w_in_ch));

    // lanes without an element field are written as zero
    for (genvar j = 0; j < LANES; j++) begin : g_row
        if (j < ncl1_pkg::NFIELDS) begin : g_field
            assign w_row[j*EW +: EW] = s_axis_tdata[FIELD0 + j*EW +: EW];
        end else begin : g_nofield
            assign w_row[j*EW +: EW] = '0;
        end
    end

    // ---------------------------------------------------------------
    // Configuration register
    // ---------------------------------------------------------------
    logic [ncl1_pkg::CFG_W-1:0] r_active;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= ncl1_pkg::ACTIVE_RESET;
        end else if (i_cfg_wen) begin
            r_active <= i_cfg_wdata;
        end
    end

    // last codeword searched: zero searches codeword 0, above VOCAB clamps
    logic [CW_W-1:0] w_last_cw;

    always_comb begin
        if (r_active == '0) begin
            w_last_cw = '0;
        end else if (32'(r_active) > 32'(VOCAB)) begin
            w_last_cw = CW_W'(VOCAB - 1);
        end else begin
            w_last_cw = CW_W'(32'(r_active) - 32'd1);
        end
    end

    // ---------------------------------------------------------------
    // Scan sequencer
    // ---------------------------------------------------------------
    ncl1_pkg::t_state r_state;
    ncl1_pkg::t_state n_state;

    logic [RA_W-1:0] r_rd_addr;
    logic [CH_W-1:0] r_rd_ch;
    logic [CW_W-1:0] r_rd_cw;
    logic [CW_W-1:0] r_last_cw;

    logic            w_issue;
    logic            w_row_first;
    logic            w_row_last;
    logic            w_row_final;
    logic            w_out_free;

    ncl1_pkg::t_tag  r_tag1;
    ncl1_pkg::t_tag  r_tag2;
    ncl1_pkg::t_tag  r_tag3;

    assign w_issue     = (r_state == ncl1_pkg::ST_SCAN);
    assign w_row_first = (r_rd_ch == '0);
    assign w_row_last  = (32'(r_rd_ch) == 32'(NCHUNKS - 1));
    assign w_row_final = w_row_last && (r_rd_cw == r_last_cw);
    assign w_out_free  = !m_axis_tvalid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ncl1_pkg::ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        case (r_state)
            ncl1_pkg::ST_IDLE: begin
                if (w_start) n_state = ncl1_pkg::ST_SCAN;
            end
            ncl1_pkg::ST_SCAN: begin
                if (w_row_final) n_state = ncl1_pkg::ST_DRAIN;
            end
            ncl1_pkg::ST_DRAIN: begin
                if (r_tag3.valid && r_tag3.final_cw) n_state = ncl1_pkg::ST_DONE;
            end
            ncl1_pkg::ST_DONE: begin
                if (w_out_free) n_state = ncl1_pkg::ST_IDLE;
            end
            default: n_state = ncl1_pkg::ST_IDLE;
        endcase
    end

    assign s_axis_tready = (r_state == ncl1_pkg::ST_IDLE);

    // row counter runs straight through codeword-major rows
    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_rd_addr <= '0;
            r_rd_ch   <= '0;
            r_rd_cw   <= '0;
            r_last_cw <= w_last_cw;
        end else if (w_issue) begin
            r_rd_addr <= r_rd_addr + RA_W'(1);
            if (w_row_last) begin
                r_rd_ch <= '0;
                r_rd_cw <= r_rd_cw + CW_W'(1);
            end else begin
                r_rd_ch <= r_rd_ch + CH_W'(1);
            end
        end
    end

    // ---------------------------------------------------------------
    // Memories: codebook rows and descriptor rows, registered reads
    // ---------------------------------------------------------------
    logic [ROW_W-1:0] r_cb_mem [ROWS];
    logic [ROW_W-1:0] r_ds_mem [NCHUNKS];
    logic [ROW_W-1:0] r_cb_q;
    logic [ROW_W-1:0] r_ds_q;
    logic [CH_W-1:0]  r_ch1;

    always_ff @(posedge i_clk) begin
        if (w_cb_we) begin
            r_cb_mem[w_cb_waddr] <= w_row;
        end
        r_cb_q <= r_cb_mem[r_rd_addr];
    end

    always_ff @(posedge i_clk) begin
        if (w_ds_we) begin
            r_ds_mem[CH_W'(w_in_ch)] <= w_row;
        end
        r_ds_q <= r_ds_mem[r_rd_ch];
    end

    always_ff @(posedge i_clk) begin
        r_ch1 <= r_rd_ch;
    end

    // tags follow the row through read, lane and merge stages
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tag1 <= '0;
            r_tag2 <= '0;
            r_tag3 <= '0;
        end else begin
            r_tag1.valid    <= w_issue;
            r_tag1.first    <= w_row_first;
            r_tag1.last     <= w_row_last;
            r_tag1.final_cw <= w_row_final;
            r_tag2          <= r_tag1;
            r_tag3          <= r_tag2;
        end
    end

    // ---------------------------------------------------------------
    // Lanes and merge
    // ---------------------------------------------------------------
    logic [LANES-1:0]                  w_lane_en;
    logic [LANES*ncl1_pkg::ABS_W-1:0]  w_absdiff;
    logic [ncl1_pkg::DIST_W-1:0]       w_row_sum;

    for (genvar j = 0; j < LANES; j++) begin : g_lane
        assign w_lane_en[j] = (32'(r_ch1) * 32'(LANES) + 32'(j)) < 32'(DIM);

        ncl1_lane u_lane (
            .i_clk     (i_clk),
            .i_en      (w_lane_en[j]),
            .i_desc    (r_ds_q[j*EW +: EW]),
            .i_code    (r_cb_q[j*EW +: EW]),
            .o_absdiff (w_absdiff[j*ncl1_pkg::ABS_W +: ncl1_pkg::ABS_W])
        );
    end

    ncl1_merge #(
        .LANES (LANES)
    ) u_merge (
        .i_clk     (i_clk),
        .i_absdiff (w_absdiff),
        .o_sum     (w_row_sum)
    );

    // ---------------------------------------------------------------
    // Accumulate per codeword and keep the running best
    // ---------------------------------------------------------------
    logic [ncl1_pkg::DIST_W-1:0] r_acc;
    logic [ncl1_pkg::DIST_W-1:0] w_acc_sum;
    logic [CW_W-1:0]             r_acc_cw;
    logic [CW_W-1:0]             r_best_idx;
    logic [ncl1_pkg::DIST_W-1:0] r_best_dist;

    assign w_acc_sum = (r_tag3.first ? '0 : r_acc) + w_row_sum;

    always_ff @(posedge i_clk) begin
        if (w_start) begin
            r_acc_cw <= '0;
        end else if (r_tag3.valid) begin
            r_acc <= w_acc_sum;
            if (r_tag3.last) begin
                r_acc_cw <= r_acc_cw + CW_W'(1);
                // codeword 0 seeds; strict compare keeps lowest index on ties
                if ((r_acc_cw == '0) || (w_acc_sum < r_best_dist)) begin
                    r_best_dist <= w_acc_sum;
                    r_best_idx  <= r_acc_cw;
                end
            end
        end
    end

    // ---------------------------------------------------------------
    // Output register
    // ---------------------------------------------------------------
    logic [31:0]                 w_best_idx_ext;
    logic [ncl1_pkg::IDX_W-1:0]  r_out_idx;
    logic [ncl1_pkg::DIST_W-1:0] r_out_dist;
    logic                        w_load_out;

    assign w_best_idx_ext = 32'(r_best_idx);
    assign w_load_out     = (r_state == ncl1_pkg::ST_DONE) && w_out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tvalid <= 1'b0;
        end else if (w_load_out) begin
            m_axis_tvalid <= 1'b1;
        end else if (m_axis_tready) begin
            m_axis_tvalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load_out) begin
            r_out_idx  <= w_best_idx_ext[ncl1_pkg::IDX_W-1:0];
            r_out_dist <= r_best_dist;
        end
    end

    assign m_axis_tdata = {
        (ncl1_pkg::OUT_TDATA_W - ncl1_pkg::DIST_W - ncl1_pkg::IDX_W)'(0),
        r_out_dist,
        r_out_idx
    };

    // ---------------------------------------------------------------
    // Assertions
    // ---------------------------------------------------------------
    a_start_scans: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_start |=> (r_state == ncl1_pkg::ST_SCAN))
        else $error("final descriptor chunk did not start a scan");

    a_tag_in_search: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_tag3.valid |-> (r_state == ncl1_pkg::ST_SCAN || r_state == ncl1_pkg::ST_DRAIN))
        else $error("pipeline row outside a search");

    a_done_emits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_load_out |=> (m_axis_tvalid && (r_state == ncl1_pkg::ST_IDLE)))
        else $error("finished search did not reach the output");

    a_dist_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> (32'(r_out_dist) <= 32'(DIM) * 32'd65535))
        else $error("distance beyond largest possible sum");

endmodule

`default_nettype wire

FILE: rtl/ncl1_lane.sv
// One absolute-difference lane: |descriptor element - codeword element|, registered.
// Depends on ncl1_pkg.
`default_nettype none

module ncl1_lane (
    input  wire logic                                 i_clk,
    input  wire logic                                 i_en,
    input  wire logic signed [ncl1_pkg::ELEM_W-1:0]   i_desc,
    input  wire logic signed [ncl1_pkg::ELEM_W-1:0]   i_code,
    output logic             [ncl1_pkg::ABS_W-1:0]    o_absdiff
);

    logic signed [ncl1_pkg::ELEM_W:0] w_diff;
    logic signed [ncl1_pkg::ELEM_W:0] w_abs;

    always_comb begin
        w_diff = {i_desc[ncl1_pkg::ELEM_W-1], i_desc} - {i_code[ncl1_pkg::ELEM_W-1], i_code};
        w_abs  = w_diff[ncl1_pkg::ELEM_W] ? -w_diff : w_diff;
    end

    // elements past the vector end contribute nothing
    always_ff @(posedge i_clk) begin
        o_absdiff <= i_en ? w_abs[ncl1_pkg::ABS_W-1:0] : '0;
    end

endmodule

`default_nettype wire

FILE: rtl/ncl1_merge.sv
// Merging stage: adds the lane differences of one row into a registered partial sum.
// Depends on ncl1_pkg.
`default_nettype none

module ncl1_merge #(
    parameter int LANES = 8
) (
    input  wire logic                                 i_clk,
    input  wire logic [LANES*ncl1_pkg::ABS_W-1:0]     i_absdiff,
    output logic      [ncl1_pkg::DIST_W-1:0]          o_sum
);

    logic [ncl1_pkg::DIST_W-1:0] w_sum;

    always_comb begin
        w_sum = '0;
        for (int j = 0; j < LANES; j++) begin
            w_sum = w_sum + ncl1_pkg::DIST_W'(i_absdiff[j*ncl1_pkg::ABS_W +: ncl1_pkg::ABS_W]);
        end
    end

    always_ff @(posedge i_clk) begin
        o_sum <= w_sum;
    end

endmodule

`default_nettype wire
